// ----- rtl/lbcs_pkg.sv -----
package lbcs_pkg;

  // Field widths
  localparam int unsigned TIME_W    = 24;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned ELAPSED_W = 25;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Register reset values
  localparam logic [TIME_W-1:0]  ON_TIME_RST   = 24'd50000;
  localparam logic [TIME_W-1:0]  OFF_TIME_RST  = 24'd400000;
  localparam logic [TIME_W-1:0]  WAIT_TIME_RST = 24'd1000000;
  localparam logic [TICK_W-1:0]  TICK_RST      = 16'd1000;
  localparam logic [COUNT_W-1:0] COUNT_RST     = 8'd0;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_ON_TIME   = 3'd0,
    REG_OFF_TIME  = 3'd1,
    REG_WAIT_TIME = 3'd2,
    REG_TICK      = 3'd3,
    REG_MODE      = 3'd4,
    REG_COUNT     = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_CAL   = 2'd0,
    MODE_CHAN  = 2'd1,
    MODE_ON    = 2'd2,
    MODE_OFF   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_WAIT_ON  = 2'd0,
    PH_WAIT_OFF = 2'd1,
    PH_ON       = 2'd2,
    PH_OFF      = 2'd3
  } phase_t;

  localparam mode_t MODE_RST = MODE_CHAN;

  typedef struct packed {
    logic [TIME_W-1:0]  on_time;
    logic [TIME_W-1:0]  off_time;
    logic [TIME_W-1:0]  wait_time;
    logic [TICK_W-1:0]  tick_period;
    mode_t              mode;
    logic [COUNT_W-1:0] blink_count;
  } cfg_t;

  typedef struct packed {
    phase_t               phase;
    logic [ELAPSED_W-1:0] elapsed;
    logic [COUNT_W-1:0]   blinks_done;
    logic                 led;
  } seq_state_t;

endpackage

// ----- rtl/lbcs_cfg_regs.sv -----
module lbcs_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output lbcs_pkg::cfg_t    cfg
);
  import lbcs_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[4:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  // Register write decode; unused indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_ON_TIME:   cfg_nxt.on_time     = cfg_pwdata[TIME_W-1:0];
        REG_OFF_TIME:  cfg_nxt.off_time    = cfg_pwdata[TIME_W-1:0];
        REG_WAIT_TIME: cfg_nxt.wait_time   = cfg_pwdata[TIME_W-1:0];
        REG_TICK:      cfg_nxt.tick_period = cfg_pwdata[TICK_W-1:0];
        REG_MODE:      cfg_nxt.mode        = mode_t'(cfg_pwdata[1:0]);
        REG_COUNT:     cfg_nxt.blink_count = cfg_pwdata[COUNT_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_time     <= ON_TIME_RST;
      cfg_r.off_time    <= OFF_TIME_RST;
      cfg_r.wait_time   <= WAIT_TIME_RST;
      cfg_r.tick_period <= TICK_RST;
      cfg_r.mode        <= MODE_RST;
      cfg_r.blink_count <= COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_ON_TIME:   cfg_prdata = {{(32-TIME_W){1'b0}}, cfg_r.on_time};
      REG_OFF_TIME:  cfg_prdata = {{(32-TIME_W){1'b0}}, cfg_r.off_time};
      REG_WAIT_TIME: cfg_prdata = {{(32-TIME_W){1'b0}}, cfg_r.wait_time};
      REG_TICK:      cfg_prdata = {{(32-TICK_W){1'b0}}, cfg_r.tick_period};
      REG_MODE:      cfg_prdata = {30'd0, cfg_r.mode};
      REG_COUNT:     cfg_prdata = {{(32-COUNT_W){1'b0}}, cfg_r.blink_count};
      default:       cfg_prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/lbcs_step.sv -----
module lbcs_step (
  input  lbcs_pkg::cfg_t       cfg,
  input  lbcs_pkg::seq_state_t st,
  input  logic                 restart,
  output lbcs_pkg::seq_state_t st_nxt
);
  import lbcs_pkg::*;

  phase_t               ph;
  logic [ELAPSED_W-1:0] el;
  logic [COUNT_W-1:0]   bd;
  logic [ELAPSED_W:0]   sum;
  logic [ELAPSED_W-1:0] el_mid;
  logic [ELAPSED_W-1:0] el_adv;
  logic                 on_hit;
  logic                 off_hit;
  logic                 wait_hit;
  logic                 timed;

  // Restart clears phase, timer and blink counter ahead of this tick
  assign ph = restart ? PH_WAIT_ON : st.phase;
  assign el = restart ? '0 : st.elapsed;
  assign bd = restart ? '0 : st.blinks_done;

  assign on_hit   = el >= {1'b0, cfg.on_time};
  assign off_hit  = el >= {1'b0, cfg.off_time};
  assign wait_hit = el >= {1'b0, cfg.wait_time};
  assign timed    = (cfg.mode == MODE_CAL) || (cfg.mode == MODE_CHAN);

  // Phase, timer and counter update
  always_comb begin
    st_nxt.phase       = ph;
    st_nxt.blinks_done = bd;
    el_mid             = el;
    case (cfg.mode)
      MODE_CHAN: begin
        case (ph)
          PH_WAIT_ON: if (wait_hit) begin
            st_nxt.phase       = PH_WAIT_OFF;
            st_nxt.blinks_done = '0;
            el_mid             = '0;
          end
          PH_WAIT_OFF: if (off_hit) begin
            st_nxt.phase       = (cfg.blink_count != '0) ? PH_ON : PH_WAIT_ON;
            st_nxt.blinks_done = '0;
            el_mid             = '0;
          end
          PH_ON: if (on_hit) begin
            st_nxt.phase       = PH_OFF;
            st_nxt.blinks_done = bd + COUNT_W'(1);
            el_mid             = '0;
          end
          default: if (off_hit) begin
            st_nxt.phase = (bd < cfg.blink_count) ? PH_ON : PH_WAIT_ON;
            el_mid       = '0;
          end
        endcase
      end
      MODE_CAL: begin
        case (ph)
          PH_OFF: if (on_hit) begin
            st_nxt.phase = PH_ON;
            el_mid       = '0;
          end
          PH_ON: if (on_hit) begin
            st_nxt.phase = PH_OFF;
            el_mid       = '0;
          end
          // a wait phase falls back to off
          default: st_nxt.phase = PH_OFF;
        endcase
      end
      default: st_nxt.phase = ph;
    endcase
  end

  // Saturating timer advance in the timed modes
  assign sum    = {1'b0, el_mid} + {{(ELAPSED_W+1-TICK_W){1'b0}}, cfg.tick_period};
  assign el_adv = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
  assign st_nxt.elapsed = timed ? el_adv : el;

  // LED level from the phase seen on this tick
  always_comb begin
    st_nxt.led = st.led;
    case (cfg.mode)
      MODE_CHAN: st_nxt.led = (ph == PH_WAIT_ON) || (ph == PH_ON);
      MODE_CAL: begin
        if (ph == PH_ON) begin
          st_nxt.led = 1'b1;
        end else if (ph == PH_OFF) begin
          st_nxt.led = 1'b0;
        end
      end
      MODE_ON:  st_nxt.led = 1'b1;
      default:  st_nxt.led = 1'b0;
    endcase
  end

endmodule

// ----- rtl/led_blink_code_sequencer.sv -----
// A result is valid in the cycle after its tick request is accepted.
// One tick is taken per cycle while out_tready is high; the single
// registered update of phase, timer and blink counter sets this rate.
// Reset (rst_n low, synchronous): registers take their default values,
// phase is wait on, timer and counter are zero, LED is dark, no result valid.
module led_blink_code_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // tick channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] restart, [7:1] zero
  // LED level channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] led_on, [7:1] zero
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lbcs_pkg::*;

  cfg_t       cfg;
  seq_state_t st_r;
  seq_state_t st_nxt;
  seq_state_t step_out;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       in_acc;

  lbcs_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lbcs_step u_step (
    .cfg     (cfg),
    .st      (st_r),
    .restart (in_tdata[0]),
    .st_nxt  (step_out)
  );

  // Take a new request whenever the result slot is free or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign st_nxt        = in_acc ? step_out : st_r;
  assign out_valid_nxt = in_acc || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase       <= PH_WAIT_ON;
      st_r.elapsed     <= '0;
      st_r.blinks_done <= '0;
      st_r.led         <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The LED register doubles as the result payload
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, st_r.led};

  // A result appears only after a tick was taken
  a_valid_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc))
    else $error("result valid without an accepted tick");

  // Constant-on mode always reports a lit LED
  a_const_on: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && cfg.mode == MODE_ON |=> out_tvalid && out_tdata[0])
    else $error("constant-on mode gave a dark LED");

  // Constant modes freeze timer and phase when no restart comes
  a_const_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_tdata[0] && (cfg.mode == MODE_ON || cfg.mode == MODE_OFF)
    |=> $stable(st_r.elapsed) && $stable(st_r.phase))
    else $error("constant mode moved timer or phase");

  // A restart in channel mode lands in one of the wait phases
  a_restart_wait: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tdata[0] && cfg.mode == MODE_CHAN
    |=> st_r.phase == PH_WAIT_ON || st_r.phase == PH_WAIT_OFF)
    else $error("restart did not return to a wait phase");

endmodule

// ----- tb/led_level_checker.sv -----
module led_level_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] restart, [7:1] zero
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [0] led_on, [7:1] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int unsigned fail_count
);
  import lbcs_pkg::*;

  // Shadow registers and sequencer state, tracked from the observed traffic
  cfg_t       shadow_cfg;
  seq_state_t seq;
  logic       expected_levels[$];

  // Register contents as a read should return them
  function automatic logic [31:0] reg_value(input logic [2:0] idx);
    case (reg_idx_t'(idx))
      REG_ON_TIME:   return {8'd0, shadow_cfg.on_time};
      REG_OFF_TIME:  return {8'd0, shadow_cfg.off_time};
      REG_WAIT_TIME: return {8'd0, shadow_cfg.wait_time};
      REG_TICK:      return {16'd0, shadow_cfg.tick_period};
      REG_MODE:      return {30'd0, shadow_cfg.mode};
      REG_COUNT:     return {24'd0, shadow_cfg.blink_count};
      default:       return '0;
    endcase
  endfunction

  // Advance the sequencer by one tick and return the new LED level
  function automatic logic next_led_level(input logic restart);
    logic [ELAPSED_W:0] sum;
    logic               timed;
    timed = 1'b1;
    if (restart) begin
      seq.phase       = PH_WAIT_ON;
      seq.elapsed     = '0;
      seq.blinks_done = '0;
    end
    case (shadow_cfg.mode)
      MODE_CAL: begin
        // toggle every on time; a wait phase drops to off, LED held
        if (seq.phase == PH_OFF) begin
          seq.led = 1'b0;
          if (seq.elapsed >= {1'b0, shadow_cfg.on_time}) begin
            seq.phase   = PH_ON;
            seq.elapsed = '0;
          end
        end else if (seq.phase == PH_ON) begin
          seq.led = 1'b1;
          if (seq.elapsed >= {1'b0, shadow_cfg.on_time}) begin
            seq.phase   = PH_OFF;
            seq.elapsed = '0;
          end
        end else begin
          seq.phase = PH_OFF;
        end
      end
      MODE_CHAN: begin
        case (seq.phase)
          PH_WAIT_ON: begin
            seq.led = 1'b1;
            if (seq.elapsed >= {1'b0, shadow_cfg.wait_time}) begin
              seq.phase       = PH_WAIT_OFF;
              seq.blinks_done = '0;
              seq.elapsed     = '0;
            end
          end
          PH_WAIT_OFF: begin
            seq.led = 1'b0;
            if (seq.elapsed >= {1'b0, shadow_cfg.off_time}) begin
              seq.phase       = (shadow_cfg.blink_count != '0) ? PH_ON : PH_WAIT_ON;
              seq.blinks_done = '0;
              seq.elapsed     = '0;
            end
          end
          PH_ON: begin
            seq.led = 1'b1;
            if (seq.elapsed >= {1'b0, shadow_cfg.on_time}) begin
              seq.blinks_done = seq.blinks_done + 8'd1;
              seq.phase       = PH_OFF;
              seq.elapsed     = '0;
            end
          end
          default: begin
            seq.led = 1'b0;
            // group ends once the current count is reached
            if (seq.elapsed >= {1'b0, shadow_cfg.off_time}) begin
              seq.phase   = (seq.blinks_done < shadow_cfg.blink_count) ? PH_ON : PH_WAIT_ON;
              seq.elapsed = '0;
            end
          end
        endcase
      end
      MODE_ON: begin
        seq.led = 1'b1;
        timed   = 1'b0;
      end
      default: begin
        seq.led = 1'b0;
        timed   = 1'b0;
      end
    endcase
    // saturating microsecond timer, frozen in the constant modes
    if (timed) begin
      sum = {1'b0, seq.elapsed} + {10'd0, shadow_cfg.tick_period};
      seq.elapsed = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
    end
    return seq.led;
  endfunction

  always @(posedge clk) begin
    logic want;
    if (!rst_n) begin
      shadow_cfg = '{on_time: ON_TIME_RST, off_time: OFF_TIME_RST,
                     wait_time: WAIT_TIME_RST, tick_period: TICK_RST,
                     mode: MODE_RST, blink_count: COUNT_RST};
      seq        = '{phase: PH_WAIT_ON, elapsed: '0, blinks_done: '0, led: 1'b0};
      expected_levels.delete();
      fail_count = 0;
    end else begin
      // LED level results against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (expected_levels.size() == 0) begin
          $error("led_on: result with no tick pending, actual %0d", out_tdata[0]);
          fail_count++;
        end else begin
          want = expected_levels.pop_front();
          if (out_tdata[0] !== want) begin
            $error("led_on mismatch: expected %0d, actual %0d", want, out_tdata[0]);
            fail_count++;
          end
        end
      end
      // tick requests
      if (in_tvalid && in_tready)
        expected_levels.push_back(next_led_level(in_tdata[0]));
      // register access phase
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (reg_idx_t'(cfg_paddr[4:2]))
            REG_ON_TIME:   shadow_cfg.on_time     = cfg_pwdata[TIME_W-1:0];
            REG_OFF_TIME:  shadow_cfg.off_time    = cfg_pwdata[TIME_W-1:0];
            REG_WAIT_TIME: shadow_cfg.wait_time   = cfg_pwdata[TIME_W-1:0];
            REG_TICK:      shadow_cfg.tick_period = cfg_pwdata[TICK_W-1:0];
            REG_MODE:      shadow_cfg.mode        = mode_t'(cfg_pwdata[1:0]);
            REG_COUNT:     shadow_cfg.blink_count = cfg_pwdata[COUNT_W-1:0];
            default: ;
          endcase
        end else if (cfg_prdata !== reg_value(cfg_paddr[4:2])) begin
          $error("prdata mismatch at 0x%0h: expected 0x%0h, actual 0x%0h",
                 cfg_paddr, reg_value(cfg_paddr[4:2]), cfg_prdata);
          fail_count++;
        end
      end
    end
  end

endmodule

// ----- tb/tb_led_blink_code_sequencer.sv -----
module tb_led_blink_code_sequencer;
  import lbcs_pkg::*;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [7:0]  out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int unsigned fail_count;

  int unsigned ticks_sent = 0;
  int unsigned levels_seen = 0;
  int unsigned stall_left = 0;
  bit          send_steady = 1'b0;
  bit          ready_steady = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  led_blink_code_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  led_level_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .fail_count (fail_count)
  );

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Time setting a few ticks long, sometimes an extreme
  function automatic logic [23:0] pick_time(input logic [15:0] tick);
    logic [63:0] t;
    case ($urandom_range(0, 9))
      0:       t = '0;
      1:       t = 64'hFF_FFFF;
      2:       t = 64'($urandom_range(0, 24'hFF_FFFF));
      default: t = 64'(tick) * $urandom_range(0, 5) + $urandom_range(0, tick);
    endcase
    if (t > 64'hFF_FFFF) t = 64'hFF_FFFF;
    return t[23:0];
  endfunction

  // Receiver back-pressure
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (!ready_steady && $urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) levels_seen++;
  end

  // One tick request; entered and left at a falling edge
  task automatic send_tick(input logic restart);
    int unsigned gap;
    gap = send_steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, restart};
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Hold off ticks until every LED level has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (levels_seen != ticks_sent) @(negedge clk);
  endtask

  task automatic cfg_access(input reg_idx_t idx, input logic wr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    cfg_access(idx, 1'b1, value);
  endtask

  // One random setting followed by a burst of ticks
  task automatic run_random_phase();
    int unsigned n_ticks;
    int unsigned pause_at;
    int unsigned r;
    logic [15:0] tick;
    r = $urandom_range(0, 9);
    tick = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 16'hFFFF));
    cfg_write(REG_TICK, {16'd0, tick});
    if ($urandom_range(0, 9) < 6) cfg_write(REG_ON_TIME, {8'd0, pick_time(tick)});
    if ($urandom_range(0, 9) < 6) cfg_write(REG_OFF_TIME, {8'd0, pick_time(tick)});
    if ($urandom_range(0, 9) < 6) cfg_write(REG_WAIT_TIME, {8'd0, pick_time(tick)});
    if ($urandom_range(0, 9) < 6) begin
      r = $urandom_range(0, 99);
      cfg_write(REG_COUNT, (r < 75) ? $urandom_range(0, 4) :
                           (r < 92) ? $urandom_range(0, 255) : 32'd255);
    end
    if ($urandom_range(0, 9) < 6) begin
      r = $urandom_range(0, 99);
      cfg_write(REG_MODE, (r < 45) ? 32'(MODE_CHAN) : (r < 75) ? 32'(MODE_CAL) :
                          (r < 88) ? 32'(MODE_ON) : 32'(MODE_OFF));
    end
    if ($urandom_range(0, 3) == 0) cfg_access(reg_idx_t'($urandom_range(0, 5)), 1'b0, '0);
    send_steady  = ($urandom_range(0, 4) == 0);
    ready_steady = ($urandom_range(0, 4) == 0);
    n_ticks  = $urandom_range(10, 60);
    pause_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n_ticks - 1) : 0;
    for (int unsigned i = 0; i < n_ticks; i++) begin
      if (pause_at != 0 && i == pause_at) drain();
      send_tick($urandom_range(0, 99) < 4);
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults: lit pause, restart in the middle
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();

    // zero thresholds at the largest tick: a phase change on every tick
    cfg_write(REG_TICK, 32'h0000_FFFF);
    cfg_write(REG_ON_TIME, 32'd0);
    cfg_write(REG_OFF_TIME, 32'd0);
    cfg_write(REG_WAIT_TIME, 32'd0);
    cfg_write(REG_COUNT, 32'd2);
    cfg_write(REG_MODE, 32'(MODE_CHAN));
    cfg_access(REG_TICK, 1'b0, '0);
    repeat (8) send_tick(1'b0);
    drain();

    // calibration entered from the on phase, then from a wait phase by restart, longest half period
    cfg_write(REG_ON_TIME, 32'h00FF_FFFF);
    cfg_write(REG_MODE, 32'(MODE_CAL));
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    drain();

    // constant modes hold timer and phase
    cfg_write(REG_MODE, 32'(MODE_ON));
    send_tick(1'b0);
    send_tick(1'b1);
    drain();
    cfg_write(REG_MODE, 32'(MODE_OFF));
    send_tick(1'b0);
    send_tick(1'b0);
    drain();

    // back to channel mode with the largest count and times
    cfg_write(REG_COUNT, 32'd255);
    cfg_write(REG_WAIT_TIME, 32'h00FF_FFFF);
    cfg_write(REG_OFF_TIME, 32'h00FF_FFFF);
    cfg_write(REG_MODE, 32'(MODE_CHAN));
    repeat (3) send_tick(1'b0);
    drain();
    cfg_access(REG_COUNT, 1'b0, '0);

    while (ticks_sent < 1125) run_random_phase();

    drain();
    repeat (5) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
